// ===== rtl/quadrature_window_counter_top_defines.svh =====
// assertion macros used by the rtl top module
`ifndef QUADRATURE_WINDOW_COUNTER_TOP_DEFINES_SVH
`define QUADRATURE_WINDOW_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define QWC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define QWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QWC_ASSERT(label, clk, rstn, prop, msg)

`define QWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/qwc_pkg.sv =====
package qwc_pkg;

    localparam int CFG_BITS = 10;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 10'd500;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET    = 10'd50;

    localparam logic [1:0] CODE_BOTH_HIGH = 2'd3;

    typedef enum logic {
        REG_PHASE_THRESHOLD = 1'b0,
        REG_WINDOW_SAMPLES  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0] stable_code;
        logic [1:0] previous_raw_code;
    } code_state_t;

    // next code in the clockwise direction: 0 -> 1 -> 3 -> 2 -> 0
    function automatic logic [1:0] cw_next(input logic [1:0] code);
        logic [1:0] nxt;
        unique case (code)
            2'd0: nxt = 2'd1;
            2'd1: nxt = 2'd3;
            2'd2: nxt = 2'd0;
            2'd3: nxt = 2'd2;
            default: nxt = 2'd0;
        endcase
        return nxt;
    endfunction

endpackage

// ===== rtl/qwc_step.sv =====
module qwc_step #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 11
) (
    input  logic [SAMPLE_BITS-1:0]        sample_a,
    input  logic [SAMPLE_BITS-1:0]        sample_b,
    input  logic [qwc_pkg::CFG_BITS-1:0]  phase_threshold,
    input  logic [qwc_pkg::CFG_BITS-1:0]  window_samples,
    input  qwc_pkg::code_state_t          codes,
    input  logic signed [COUNT_BITS-1:0]  acc,
    input  logic [qwc_pkg::CFG_BITS-1:0]  pos,
    output qwc_pkg::code_state_t          codes_next,
    output logic signed [COUNT_BITS-1:0]  acc_next,
    output logic [qwc_pkg::CFG_BITS-1:0]  pos_next,
    output logic                          emit,
    output logic signed [COUNT_BITS-1:0]  report
);

    localparam int CMP_BITS = (SAMPLE_BITS > qwc_pkg::CFG_BITS) ? SAMPLE_BITS
                                                                : qwc_pkg::CFG_BITS;
    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [CMP_BITS-1:0]          a_ext;
    logic [CMP_BITS-1:0]          b_ext;
    logic [CMP_BITS-1:0]          thr_ext;
    logic [1:0]                   raw;
    logic                         take;
    logic                         step_up;
    logic                         step_dn;
    logic signed [COUNT_BITS-1:0] acc_step;
    logic [qwc_pkg::CFG_BITS-1:0] win;
    logic [qwc_pkg::CFG_BITS-1:0] pos_inc;

    always_comb begin
        a_ext   = CMP_BITS'(sample_a);
        b_ext   = CMP_BITS'(sample_b);
        thr_ext = CMP_BITS'(phase_threshold);
        raw     = {b_ext > thr_ext, a_ext > thr_ext};

        take    = (raw == codes.previous_raw_code) && (raw != codes.stable_code);
        step_up = take && (qwc_pkg::cw_next(codes.stable_code) == raw);
        step_dn = take && !step_up && (qwc_pkg::cw_next(raw) == codes.stable_code);

        acc_step = acc;
        if (step_up && (acc != CNT_MAX)) begin
            acc_step = acc + COUNT_BITS'(1);
        end else if (step_dn && (acc != CNT_MIN)) begin
            acc_step = acc - COUNT_BITS'(1);
        end

        codes_next.stable_code       = take ? raw : codes.stable_code;
        codes_next.previous_raw_code = raw;

        // a zero window acts as one sample
        win     = (window_samples == '0) ? qwc_pkg::CFG_BITS'(1) : window_samples;
        pos_inc = pos + qwc_pkg::CFG_BITS'(1);
        emit    = (pos_inc >= win);

        report   = acc_step;
        acc_next = emit ? '0 : acc_step;
        pos_next = emit ? '0 : pos_inc;
    end

endmodule

// ===== rtl/quadrature_window_counter_top.sv =====
// path: an input beat passes the input register and then the result register on its way to m_tdata
// throughput: one sample beat per cycle; a stall only arises when a window
// closes while the result register still holds an untaken beat
// reset: synchronous active-low aresetn; registers return to threshold 500,
// window 50, both codes high, count and window position zero
`include "quadrature_window_counter_top_defines.svh"

module quadrature_window_counter_top #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 11
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample_a, sample_b, zero pad

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((COUNT_BITS+7)/8)*8-1:0]      m_tdata,   // net_count, zero pad

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int IN_BYTES  = (2*SAMPLE_BITS + 7) / 8;
    localparam int OUT_BYTES = (COUNT_BITS + 7) / 8;
    localparam int CFG_BITS  = qwc_pkg::CFG_BITS;

    logic [CFG_BITS-1:0]          threshold_reg;
    logic [CFG_BITS-1:0]          window_reg;
    qwc_pkg::reg_index_t          reg_sel;
    logic                         cfg_write;

    logic                         in_valid_reg;
    logic [SAMPLE_BITS-1:0]       sample_a_reg;
    logic [SAMPLE_BITS-1:0]       sample_b_reg;

    qwc_pkg::code_state_t         codes_reg;
    qwc_pkg::code_state_t         codes_next;
    logic signed [COUNT_BITS-1:0] acc_reg;
    logic signed [COUNT_BITS-1:0] acc_next;
    logic [CFG_BITS-1:0]          pos_reg;
    logic [CFG_BITS-1:0]          pos_next;
    logic                         emit;
    logic signed [COUNT_BITS-1:0] report;

    logic                         out_valid_reg;
    logic signed [COUNT_BITS-1:0] out_count_reg;
    logic                         advance;

    // config port
    assign pready    = 1'b1;
    assign reg_sel   = qwc_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= qwc_pkg::THRESHOLD_RESET;
            window_reg    <= qwc_pkg::WINDOW_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                qwc_pkg::REG_PHASE_THRESHOLD: threshold_reg <= pwdata[CFG_BITS-1:0];
                qwc_pkg::REG_WINDOW_SAMPLES:  window_reg    <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            qwc_pkg::REG_PHASE_THRESHOLD: prdata = 32'(threshold_reg);
            qwc_pkg::REG_WINDOW_SAMPLES:  prdata = 32'(window_reg);
            default:                      prdata = '0;
        endcase
    end

    // handshake
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (OUT_BYTES*8)'($unsigned(out_count_reg));

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_a_reg <= s_tdata[SAMPLE_BITS-1:0];
            sample_b_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    qwc_step #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_step (
        .sample_a        (sample_a_reg),
        .sample_b        (sample_b_reg),
        .phase_threshold (threshold_reg),
        .window_samples  (window_reg),
        .codes           (codes_reg),
        .acc             (acc_reg),
        .pos             (pos_reg),
        .codes_next      (codes_next),
        .acc_next        (acc_next),
        .pos_next        (pos_next),
        .emit            (emit),
        .report          (report)
    );

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.stable_code       <= qwc_pkg::CODE_BOTH_HIGH;
            codes_reg.previous_raw_code <= qwc_pkg::CODE_BOTH_HIGH;
            acc_reg                     <= '0;
            pos_reg                     <= '0;
        end else if (advance) begin
            codes_reg <= codes_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_count_reg <= report;
        end
    end

    `QWC_ASSERT(a_stall_holds_item, aclk, aresetn, !s_tready |-> in_valid_reg, "stall without a held beat")
    `QWC_ASSERT_NEXT(a_window_clears, aclk, aresetn, advance && emit, (pos_reg == '0) && (acc_reg == '0), "window did not clear after report")
    `QWC_ASSERT_NEXT(a_codes_idle, aclk, aresetn, !advance, $stable(codes_reg), "codes changed without a beat")

endmodule

// ===== sim/net_count_checker.sv =====
module net_count_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // sample_a, sample_b, zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // net_count, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          counts_waiting,
    output int          samples_seen,
    output int          windows_seen
);

    localparam int COUNT_MAX = 1023;
    localparam int COUNT_MIN = -1024;
    localparam logic [2:0] ADDR_THRESHOLD = {qwc_pkg::REG_PHASE_THRESHOLD, 2'b00};
    localparam logic [2:0] ADDR_WINDOW    = {qwc_pkg::REG_WINDOW_SAMPLES, 2'b00};

    logic [9:0]        threshold;
    logic [9:0]        window_len;
    logic [9:0]        window_pos;
    logic [1:0]        stable_code;
    logic [1:0]        last_raw;
    int                step_sum;
    logic signed [10:0] window_counts [$];
    logic signed [10:0] want;
    int                fails = 0;
    int                samples = 0;
    int                windows = 0;

    function automatic logic [1:0] clockwise_of(input logic [1:0] code);
        case (code)
            2'd0: return 2'd1;
            2'd1: return 2'd3;
            2'd2: return 2'd0;
            default: return 2'd2;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    task automatic decode_sample(input logic [9:0] a, input logic [9:0] b);
        logic [1:0] raw;
        logic [9:0] win;
        raw = {b > threshold, a > threshold};
        if (raw == last_raw && raw != stable_code) begin
            if (clockwise_of(stable_code) == raw) begin
                step_sum = (step_sum + 1 > COUNT_MAX) ? COUNT_MAX : step_sum + 1;
            end else if (clockwise_of(raw) == stable_code) begin
                step_sum = (step_sum - 1 < COUNT_MIN) ? COUNT_MIN : step_sum - 1;
            end
            stable_code = raw;
        end
        last_raw = raw;
        win = (window_len == 10'd0) ? 10'd1 : window_len;
        window_pos = window_pos + 10'd1;
        if (window_pos >= win) begin
            window_counts.push_back(11'(step_sum));
            step_sum = 0;
            window_pos = 10'd0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold   = qwc_pkg::THRESHOLD_RESET;
            window_len  = qwc_pkg::WINDOW_RESET;
            window_pos  = 10'd0;
            stable_code = qwc_pkg::CODE_BOTH_HIGH;
            last_raw    = qwc_pkg::CODE_BOTH_HIGH;
            step_sum    = 0;
            window_counts.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_THRESHOLD) begin
                    threshold = pwdata[9:0];
                end else if (paddr == ADDR_WINDOW) begin
                    window_len = pwdata[9:0];
                end
            end
            if (m_tvalid && m_tready) begin
                windows++;
                if (window_counts.size() == 0) begin
                    report_mismatch($sformatf("net_count %0d with no window pending",
                                              $signed(m_tdata[10:0])));
                end else begin
                    want = window_counts.pop_front();
                    if (m_tdata[10:0] !== want) begin
                        report_mismatch($sformatf("net_count got %0d want %0d",
                                                  $signed(m_tdata[10:0]), want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                samples++;
                decode_sample(s_tdata[9:0], s_tdata[19:10]);
            end
        end
        mismatches     <= fails;
        counts_waiting <= window_counts.size();
        samples_seen   <= samples;
        windows_seen   <= windows;
    end

endmodule

// ===== sim/quadrature_window_counter_top_test.sv =====
module quadrature_window_counter_top_test;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;    // sample_a, sample_b, zero pad
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;          // net_count, zero pad
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          counts_waiting;
    int          samples_seen;
    int          windows_seen;

    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          settings    = 1;
    int          stall_left  = 0;
    int          stall_mode  = 0;
    int          mode_age    = 0;
    logic [9:0]  threshold_now = qwc_pkg::THRESHOLD_RESET;
    logic [1:0]  shaft_code    = qwc_pkg::CODE_BOTH_HIGH;

    int phase_thr [0:9] = '{0, 1023, 512, 500, 1, 1022, -1, -1, -1, 500};
    int phase_win [0:9] = '{1, 2, 1023, 3, 7, 4, 12, 0, 5, 20};
    int phase_index;

    always #10 aclk = ~aclk;

    quadrature_window_counter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    net_count_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .counts_waiting (counts_waiting),
        .samples_seen   (samples_seen),
        .windows_seen   (windows_seen)
    );

    always @(posedge aclk) begin
        if (mode_age == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_age = $urandom_range(50, 300);
        end
        mode_age--;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
                3: stall_left = $urandom_range(0, 2);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[quadrature_window_counter_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [9:0] phase_level(input logic high, input logic [9:0] thr);
        logic [9:0] v;
        if (high && thr != 10'd1023) begin
            if ($urandom_range(0, 7) == 0) begin
                v = ($urandom_range(0, 1) == 0) ? thr + 10'd1 : 10'd1023;
            end else begin
                v = 10'($urandom_range(int'(thr) + 1, 1023));
            end
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                v = ($urandom_range(0, 1) == 0) ? thr : 10'd0;
            end else begin
                v = 10'($urandom_range(0, int'(thr)));
            end
        end
        return v;
    endfunction

    task automatic send_pair(input logic [9:0] a, input logic [9:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, a};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_code(input logic [1:0] code);
        send_pair(phase_level(code[0], threshold_now), phase_level(code[1], threshold_now));
    endtask

    // encoder motion: held steps both ways, jumps, one-beat glitches and raw noise
    task automatic run_motion(input int n);
        int sent;
        int hold;
        int pick;
        logic [1:0] target;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_pair(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                sent++;
            end else if (pick < 18) begin
                send_code(shaft_code ^ 2'($urandom_range(1, 3)));
                sent++;
            end else begin
                if (pick < 55) begin
                    target = {shaft_code[0], ~shaft_code[1]};
                end else if (pick < 88) begin
                    target = {~shaft_code[0], shaft_code[1]};
                end else if (pick < 95) begin
                    target = ~shaft_code;
                end else begin
                    target = shaft_code;
                end
                hold = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
                shaft_code = target;
                repeat (hold) begin
                    send_code(target);
                    sent++;
                end
            end
        end
    endtask

    task automatic drain_counts();
        repeat (2) @(posedge aclk);
        while (counts_waiting != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input qwc_pkg::reg_index_t idx, input logic [9:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {22'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == qwc_pkg::REG_PHASE_THRESHOLD) threshold_now = val;
    endtask

    task automatic configure(input logic [9:0] thr, input logic [9:0] win);
        s_tvalid <= 1'b0;
        drain_counts();
        repeat (4) @(posedge aclk);
        apb_write(qwc_pkg::REG_PHASE_THRESHOLD, thr);
        apb_write(qwc_pkg::REG_WINDOW_SAMPLES, win);
        settings++;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold edges, steps both ways, jump, glitch
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd500, 10'd501);
        send_pair(10'd0, 10'd0);
        send_pair(10'd0, 10'd0);
        send_pair(10'd501, 10'd0);
        send_pair(10'd501, 10'd0);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd501, 10'd0);
        send_pair(10'd501, 10'd0);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd0, 10'd1023);

        // zero window shrunk mid-window, step on the closing beat
        configure(10'd0, 10'd0);
        send_pair(10'd0, 10'd0);
        send_pair(10'd0, 10'd0);
        send_pair(10'd1, 10'd1);
        send_pair(10'd1, 10'd1);

        configure(10'd1023, 10'd1023);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd1023, 10'd1023);
        shaft_code = 2'd0;

        for (phase_index = 0; phase_index < 10; phase_index++) begin
            configure((phase_thr[phase_index] < 0) ? 10'($urandom_range(0, 1023))
                                                   : 10'(phase_thr[phase_index]),
                      10'(phase_win[phase_index]));
            run_motion(60);
        end

        s_tvalid <= 1'b0;
        drain_counts();
        repeat (8) @(posedge aclk);
        $display("covered %0d sample beats and %0d window reports", samples_seen, windows_seen);
        $display("across %0d threshold and window settings", settings);
        if (mismatches == 0 && counts_waiting == 0) begin
            $display("[quadrature_window_counter_top] OK");
        end else begin
            $display("[quadrature_window_counter_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qwc_pkg.sv
rtl/qwc_step.sv
rtl/quadrature_window_counter_top.sv
sim/net_count_checker.sv
sim/quadrature_window_counter_top_test.sv
